// ===== rtl/ttb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_pkg - shared types and constants for the tag-to-bit registry
// Result status codes, fixed field widths and the lookup summary struct.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int TAG_W    = 32;
    localparam int MASK_W   = 32;
    localparam int IDX_W    = 5;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_LIST_OK   = 3'd3,
        ST_LIST_MISS = 3'd4
    } t_status;

    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_LIST     = 1'b1;

    // idx is the matching entry on a hit, else the fill count (the next free slot when not full)
    typedef struct packed {
        logic             hit;
        logic             full;
        logic [IDX_W-1:0] idx;
    } t_lookup;

endpackage
`default_nettype wire

// ===== rtl/ttb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_item_if / ttb_result_if - valid/ready channels of the registry
// One word moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface ttb_item_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [ttb_pkg::TAG_W-1:0] tag_value;
    logic                      last_in_list;

    modport source (output valid, output kind, output tag_value, output last_in_list,
                    input ready);
    modport sink   (input valid, input kind, input tag_value, input last_in_list,
                    output ready);
endinterface

interface ttb_result_if;
    logic                         valid;
    logic                         ready;
    logic [ttb_pkg::STATUS_W-1:0] status;
    logic [ttb_pkg::IDX_W-1:0]    bit_index;
    logic [ttb_pkg::MASK_W-1:0]   result_mask;

    modport source (output valid, output status, output bit_index, output result_mask,
                    input ready);
    modport sink   (input valid, input status, input bit_index, input result_mask,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/ttb_tag_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_tag_store - tag table with parallel compare
// Holds the registered tags and the fill count; compares a key with every
// filled entry at once and appends it on request.
// ----------------------------------------------------------------------------
module ttb_tag_store #(
    parameter int DEPTH = 32,
    parameter int KEY_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic             i_insert,
    output ttb_pkg::t_lookup      o_lookup
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KEY_W-1:0] r_table [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [DEPTH-1:0] match;
    logic [ttb_pkg::IDX_W-1:0] match_idx;

    always_comb begin
        match_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (CNT_W'(i) < r_count) && (r_table[i] == i_key);
            // entries are unique, so at most one bit is set
            if (match[i]) begin
                match_idx = match_idx | ttb_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_lookup.hit  = |match;
        o_lookup.full = (r_count == CNT_W'(DEPTH));
        o_lookup.idx  = o_lookup.hit ? match_idx : ttb_pkg::IDX_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_insert) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            r_table[r_count[SLOT_W-1:0]] <= i_key;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ttb_resolve.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_resolve - result forming, list accumulation and result register
// Turns a lookup into a result word, ORs list bits until the last element,
// and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module ttb_resolve (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic             i_kind,
    input  wire logic             i_last,
    input  wire ttb_pkg::t_lookup i_lookup,
    output logic                  o_free,
    ttb_result_if.source          o_result
);

    logic                           r_valid;
    ttb_pkg::t_status               r_status;
    logic [ttb_pkg::IDX_W-1:0]      r_index;
    logic [ttb_pkg::MASK_W-1:0]     r_mask;
    logic [ttb_pkg::MASK_W-1:0]     r_list_mask;
    logic                           r_list_miss;

    logic [ttb_pkg::MASK_W-1:0]     onehot;
    logic [ttb_pkg::MASK_W-1:0]     n_list_mask;
    logic                           n_list_miss;
    logic                           produce;
    ttb_pkg::t_status               n_status;
    logic [ttb_pkg::IDX_W-1:0]      n_index;
    logic [ttb_pkg::MASK_W-1:0]     n_mask;

    assign onehot      = ttb_pkg::MASK_W'(1) << i_lookup.idx;
    assign n_list_mask = r_list_mask | (i_lookup.hit ? onehot : '0);
    assign n_list_miss = r_list_miss | ~i_lookup.hit;
    assign produce     = (i_kind == ttb_pkg::KIND_REGISTER) || i_last;

    always_comb begin
        n_status = ttb_pkg::ST_FULL;
        n_index  = '0;
        n_mask   = '0;
        if (i_kind == ttb_pkg::KIND_REGISTER) begin
            if (i_lookup.hit) begin
                n_status = ttb_pkg::ST_FOUND;
                n_index  = i_lookup.idx;
                n_mask   = onehot;
            end else if (!i_lookup.full) begin
                n_status = ttb_pkg::ST_ADDED;
                n_index  = i_lookup.idx;
                n_mask   = onehot;
            end
        end else if (n_list_miss) begin
            n_status = ttb_pkg::ST_LIST_MISS;
        end else begin
            n_status = ttb_pkg::ST_LIST_OK;
            n_mask   = n_list_mask;
        end
    end

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_list_mask <= '0;
            r_list_miss <= 1'b0;
        end else begin
            if (i_fire && produce) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
            if (i_fire && (i_kind == ttb_pkg::KIND_LIST)) begin
                r_list_mask <= i_last ? '0 : n_list_mask;
                r_list_miss <= i_last ? 1'b0 : n_list_miss;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && produce) begin
            r_status <= n_status;
            r_index  <= n_index;
            r_mask   <= n_mask;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.status      = r_status;
    assign o_result.bit_index   = r_index;
    assign o_result.result_mask = r_mask;

endmodule
`default_nettype wire

// ===== rtl/tag_to_bit_registry.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tag_to_bit_registry - associative tag-to-bit registry
// Path: an accepted word goes from the input register to the result register.
// Throughput: one word per cycle unless the result register is stalled, set by
// the combinational parallel tag compare between the input and result registers.
// Reset: synchronous; empties the table, clears the open list and both stages.
// Table contents are not cleared; only entries below the fill count are used.
// ----------------------------------------------------------------------------
module tag_to_bit_registry #(
    parameter int TABLE_DEPTH = 32,
    parameter int TAG_WIDTH   = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ttb_item_if.sink     i_item,
    ttb_result_if.source o_result
);

    localparam int KEY_W = (TAG_WIDTH < ttb_pkg::TAG_W) ? TAG_WIDTH : ttb_pkg::TAG_W;

    logic             r_in_valid;
    logic             r_kind;
    logic [KEY_W-1:0] r_key;
    logic             r_last;

    ttb_pkg::t_lookup lookup;
    logic             out_free;
    logic             advance;
    logic             insert;

    assign advance = r_in_valid
                     && (out_free || ((r_kind == ttb_pkg::KIND_LIST) && !r_last));
    assign insert  = advance && (r_kind == ttb_pkg::KIND_REGISTER)
                     && !lookup.hit && !lookup.full;
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_kind <= i_item.kind;
            r_key  <= i_item.tag_value[KEY_W-1:0];
            r_last <= i_item.last_in_list;
        end
    end

    ttb_tag_store #(
        .DEPTH (TABLE_DEPTH),
        .KEY_W (KEY_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (r_key),
        .i_insert (insert),
        .o_lookup (lookup)
    );

    ttb_resolve u_resolve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_kind   (r_kind),
        .i_last   (r_last),
        .i_lookup (lookup),
        .o_free   (out_free),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/ttb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_checker - port-level checks for the tag-to-bit registry
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ttb_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [ttb_pkg::STATUS_W-1:0] i_status,
    input wire logic [ttb_pkg::IDX_W-1:0]    i_bit_index,
    input wire logic [ttb_pkg::MASK_W-1:0]   i_result_mask
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_bit_index) && $stable(i_result_mask))
        else $error("stalled result word changed");

    a_reg_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ttb_pkg::ST_FOUND || i_status == ttb_pkg::ST_ADDED)
            |-> $onehot(i_result_mask)
                && (i_result_mask == (ttb_pkg::MASK_W'(1) << i_bit_index)))
        else $error("register result mask does not match its index");

    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ttb_pkg::ST_FULL || i_status == ttb_pkg::ST_LIST_OK
                        || i_status == ttb_pkg::ST_LIST_MISS)
            |-> i_bit_index == '0)
        else $error("non-zero index on full or list result");

    a_zero_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ttb_pkg::ST_FULL || i_status == ttb_pkg::ST_LIST_MISS)
            |-> i_result_mask == '0)
        else $error("non-zero mask on full or miss result");

endmodule

bind tag_to_bit_registry ttb_checker u_ttb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_bit_index   (o_result.bit_index),
    .i_result_mask (o_result.result_mask)
);
`default_nettype wire
